FILE: design/catmull_rom_path_interpolator_unit_defines.svh
// Assertion macros used by the checker file of the path interpolator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CATMULL_ROM_PATH_INTERPOLATOR_UNIT_DEFINES_SVH
`define CATMULL_ROM_PATH_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CRPI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CRPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/crpi_pkg.sv
// Shared types and constants of the Catmull-Rom path interpolator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package crpi_pkg;

    // Register file: width of the rate register and of the APB address.
    localparam int RATE_W      = 17;
    localparam int RATE_RESET  = 4096;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index as carried in paddr[2].
    localparam logic REG_STEP_RATE = 1'b0;

    // Results per segment are capped at this count (one slot is kept for the endpoint).
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 6;

    // Window depth and the fill count at which interpolation starts.
    localparam int WIN_DEPTH       = 4;
    localparam logic [2:0] HELD_FULL = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC,
        ST_PUT,
        ST_END
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } blend_stat_t;

endpackage

FILE: design/crpi_blend.sv
// Shared multiply-accumulate unit that evaluates one Catmull-Rom sample.
// Depends on crpi_pkg; driven by the sequencer in the top level.
`timescale 1ns / 1ps

module crpi_blend
    import crpi_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int PHASE_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [PHASE_BITS-1:0]         phase,
    input  logic signed [COORD_WIDTH-1:0] win_x [WIN_DEPTH],
    input  logic signed [COORD_WIDTH-1:0] win_y [WIN_DEPTH],
    output blend_stat_t                   stat,
    output logic signed [COORD_WIDTH-1:0] smp_x,
    output logic signed [COORD_WIDTH-1:0] smp_y
);

    localparam int MAW = (COORD_WIDTH > PHASE_BITS + 1) ? COORD_WIDTH : PHASE_BITS + 1;
    localparam int WW  = PHASE_BITS + 4;
    localparam int PW  = MAW + WW;
    localparam int AW  = PW + 3;
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_SQ    = OP_W'(0);
    localparam logic [OP_W-1:0] OP_CUBE  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_WGT   = OP_W'(2);
    localparam logic [OP_W-1:0] OP_TERM0 = OP_W'(3);
    localparam logic [OP_W-1:0] OP_YACC0 = OP_W'(8);
    localparam logic [OP_W-1:0] OP_DONE  = OP_W'(12);
    localparam logic signed [WW-1:0] S_W = WW'(1) <<< PHASE_BITS;
    localparam logic signed [AW-1:0] S_A = AW'(1) <<< PHASE_BITS;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    logic [OP_W-1:0]         op_reg;
    logic                    busy_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [PHASE_BITS-1:0]   t2_reg;
    logic signed [WW-1:0]    w_reg [WIN_DEPTH];
    logic signed [AW-1:0]    acc_x_reg;
    logic signed [AW-1:0]    acc_y_reg;

    logic signed [MAW-1:0]   mul_a;
    logic signed [WW-1:0]    mul_b;
    logic [PHASE_BITS-1:0]   prod_hi;
    logic [2:0]              term;
    logic signed [COORD_WIDTH-1:0] coord;
    logic signed [WW-1:0]    st, st2, st3;
    logic signed [WW-1:0]    w_next [WIN_DEPTH];

    function automatic logic signed [COORD_WIDTH-1:0] sat_c(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] sh;
        sh = v >>> (PHASE_BITS + 1);
        if (sh > SAT_HI)
            return SAT_HI[COORD_WIDTH-1:0];
        else if (sh < SAT_LO)
            return SAT_LO[COORD_WIDTH-1:0];
        else
            return sh[COORD_WIDTH-1:0];
    endfunction

    assign prod_hi = prod_reg[2*PHASE_BITS-1:PHASE_BITS];
    assign term    = 3'(op_reg - OP_TERM0);
    assign coord   = term[2] ? win_y[term[1:0]] : win_x[term[1:0]];

    // Weights are formed from t, t^2 and t^3 in the same fixed-point scale.
    always_comb
    begin
        st  = $signed({{(WW-PHASE_BITS){1'b0}}, phase});
        st2 = $signed({{(WW-PHASE_BITS){1'b0}}, t2_reg});
        st3 = $signed({{(WW-PHASE_BITS){1'b0}}, prod_hi});
        w_next[0] = -st3 + (st2 <<< 1) - st;
        w_next[1] = (st3 <<< 1) + st3 - (st2 <<< 2) - st2 + (S_W <<< 1);
        w_next[2] = -(st3 <<< 1) - st3 + (st2 <<< 2) + st;
        w_next[3] = st3 - st2;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (op_reg == OP_SQ)
        begin
            mul_a = $signed({{(MAW-PHASE_BITS){1'b0}}, phase});
            mul_b = $signed({{(WW-PHASE_BITS){1'b0}}, phase});
        end
        else if (op_reg == OP_CUBE)
        begin
            mul_a = $signed({{(MAW-PHASE_BITS){1'b0}}, prod_hi});
            mul_b = $signed({{(WW-PHASE_BITS){1'b0}}, phase});
        end
        else if (op_reg >= OP_TERM0 && op_reg < OP_TERM0 + OP_W'(8))
        begin
            mul_a = MAW'(coord);
            mul_b = w_reg[term[1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            op_reg   <= OP_SQ;
        end
        else if (busy_reg)
        begin
            op_reg <= op_reg + OP_W'(1);
            if (op_reg == OP_DONE)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (busy_reg && op_reg == OP_CUBE)
            t2_reg <= prod_hi;
        if (busy_reg && op_reg == OP_WGT)
            w_reg <= w_next;
        if (busy_reg && op_reg == OP_TERM0)
        begin
            acc_x_reg <= S_A;
            acc_y_reg <= S_A;
        end
        else if (busy_reg && op_reg > OP_TERM0 && op_reg <= OP_YACC0 - OP_W'(1) + OP_W'(1)
                 && op_reg < OP_YACC0)
            acc_x_reg <= acc_x_reg + AW'(prod_reg);
        else if (busy_reg && op_reg >= OP_YACC0 && op_reg < OP_DONE)
            acc_y_reg <= acc_y_reg + AW'(prod_reg);
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (op_reg == OP_DONE);
    assign smp_x     = sat_c(acc_x_reg);
    assign smp_y     = sat_c(acc_y_reg);

endmodule

FILE: design/catmull_rom_path_interpolator_unit.sv
// Catmull-Rom path interpolator: top level with sequencer, point window and APB register.
// Depends on crpi_pkg and crpi_blend.
//
// Usage: control points enter on the s_axis channel, x in tdata[15:0], y in tdata[31:16]
// and the path-end mark on tlast. Interpolated samples leave on the m_axis channel in
// the same packing, with tlast marking the endpoint sample that closes a path.
// Once four points are held, every new point produces the samples of the middle
// segment of the window, spaced by the step_rate register (APB address 0).
// Each sample is made in turn: the sequencer starts the shared multiply-accumulate
// unit, which forms t^2, t^3, the weights and eight coordinate products and
// accumulates them, and the result is handed to the output register. A point
// produces up to 63 samples, plus the endpoint on a path-end point. The input
// is not ready while a point is in work. The output register holds a finished
// sample while the receiver stalls; the sequencer waits for it to drain, and a
// new point can be taken while the last sample of the previous one still waits there.
// Reset empties the window, sets step_rate to 4096 and the phase to the rate;
// no clearing pass is needed. step_rate is to be written by the user only while the
// block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module catmull_rom_path_interpolator_unit
    import crpi_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int PHASE_BITS  = 16,
    localparam int TD_W = ((2 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input points.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TD_W-1:0]       s_axis_tdata,   // point_x, point_y, zero fill
    input  logic                  s_axis_tlast,   // last_point
    // Interpolated samples.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TD_W-1:0]       m_axis_tdata,   // out_x, out_y, zero fill
    output logic                  m_axis_tlast,   // end_of_path
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = COORD_WIDTH;
    localparam int PB = PHASE_BITS;
    localparam logic [31:0] ONE32 = 32'(1) << PB;
    localparam int PHASE_RST = (RATE_RESET > (1 << PB)) ? (1 << PB) : RATE_RESET;

    state_t state_reg, state_next;

    logic signed [CW-1:0] win_x_reg [WIN_DEPTH];
    logic signed [CW-1:0] win_y_reg [WIN_DEPTH];
    logic [2:0]           held_reg;
    logic [PB:0]          phase_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 last_reg;
    logic                 end_newest_reg;
    logic                 out_valid_reg;
    logic signed [CW-1:0] out_x_reg;
    logic signed [CW-1:0] out_y_reg;
    logic                 out_end_reg;

    logic                 accept;
    logic [2:0]           held_next;
    logic                 loop_go;
    logic                 out_free;
    logic                 blend_start;
    logic                 put_sample;
    logic                 put_end;
    logic                 cfg_write;
    logic [PB:0]          eff_rate;
    logic signed [CW-1:0] px, py;
    blend_stat_t          bstat;
    logic signed [CW-1:0] smp_x, smp_y;

    // A rate above one segment per sample behaves as exactly one.
    function automatic logic [PB:0] eff_of(input logic [RATE_W-1:0] r);
        if (32'(r) > ONE32)
            return (PB+1)'(ONE32);
        else
            return (PB+1)'(r);
    endfunction

    assign px        = s_axis_tdata[CW-1:0];
    assign py        = s_axis_tdata[2*CW-1:CW];
    assign eff_rate  = eff_of(rate_reg);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign held_next = (held_reg == HELD_FULL) ? held_reg : held_reg + 3'd1;
    assign out_free  = !out_valid_reg || m_axis_tready;
    // Another sample is due while the phase is below one and the segment is not full.
    assign loop_go   = !phase_reg[PB] && (cnt_reg < CNT_W'(MAX_RESULTS - 1));
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_STEP_RATE);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (held_next == HELD_FULL)
                        state_next = ST_CHECK;
                    else if (s_axis_tlast)
                        state_next = ST_END;
                end
            end
            ST_CHECK:
            begin
                if (loop_go)
                    state_next = ST_CALC;
                else if (last_reg)
                    state_next = ST_END;
                else
                    state_next = ST_IDLE;
            end
            ST_CALC:
            begin
                if (bstat.done)
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                    state_next = ST_CHECK;
            end
            ST_END:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decoding of the sequencer.
    always_comb
    begin
        s_axis_tready = 1'b0;
        blend_start   = 1'b0;
        put_sample    = 1'b0;
        put_end       = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CHECK: blend_start   = loop_go;
            ST_CALC:  ;
            ST_PUT:   put_sample    = out_free;
            ST_END:   put_end       = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
            held_reg       <= '0;
            phase_reg      <= (PB+1)'(PHASE_RST);
            rate_reg       <= RATE_W'(RATE_RESET);
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            end_newest_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new sample or endpoint refills the output register in the same
            // cycle in which the receiver takes the old one.
            if (put_sample || put_end)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            if (accept)
            begin
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    win_x_reg[i] <= win_x_reg[i+1];
                    win_y_reg[i] <= win_y_reg[i+1];
                end
                win_x_reg[WIN_DEPTH-1] <= px;
                win_y_reg[WIN_DEPTH-1] <= py;
                held_reg       <= held_next;
                last_reg       <= s_axis_tlast;
                end_newest_reg <= (held_next != HELD_FULL);
                cnt_reg        <= '0;
            end

            // Segment finished: carry the phase over, or drop it when the cap was hit.
            if (state_reg == ST_CHECK && !loop_go)
                phase_reg <= phase_reg[PB] ? {1'b0, phase_reg[PB-1:0]} : '0;

            if (put_sample)
            begin
                phase_reg     <= phase_reg + eff_rate;
                cnt_reg       <= cnt_reg + CNT_W'(1);
            end

            if (put_end)
            begin
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    win_x_reg[i] <= '0;
                    win_y_reg[i] <= '0;
                end
                held_reg  <= '0;
                phase_reg <= eff_rate;
            end

            if (cfg_write)
            begin
                rate_reg <= pwdata[RATE_W-1:0];
                if (held_reg == '0)
                    phase_reg <= eff_of(pwdata[RATE_W-1:0]);
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (put_sample)
        begin
            out_x_reg   <= smp_x;
            out_y_reg   <= smp_y;
            out_end_reg <= 1'b0;
        end
        else if (put_end)
        begin
            out_x_reg   <= end_newest_reg ? win_x_reg[3] : win_x_reg[2];
            out_y_reg   <= end_newest_reg ? win_y_reg[3] : win_y_reg[2];
            out_end_reg <= 1'b1;
        end
    end

    crpi_blend #(
        .COORD_WIDTH (COORD_WIDTH),
        .PHASE_BITS  (PHASE_BITS)
    ) u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .phase (phase_reg[PB-1:0]),
        .win_x (win_x_reg),
        .win_y (win_y_reg),
        .stat  (bstat),
        .smp_x (smp_x),
        .smp_y (smp_y)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TD_W'({out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_end_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_STEP_RATE) ? APB_DATA_W'(rate_reg) : '0;

endmodule

FILE: design/crpi_checker.sv
// Port-level assertions for the path interpolator, bound to its top level.
// Depends on crpi_pkg and catmull_rom_path_interpolator_unit_defines.svh.
`timescale 1ns / 1ps
`include "catmull_rom_path_interpolator_unit_defines.svh"

module crpi_checker
    import crpi_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    // A stalled sample stays offered.
    `CRPI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "sample dropped while stalled")

    // A path-end point always leaves work pending, so the input is not ready in the following cycle.
    `CRPI_ASSERT_NEXT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input open right after path end")

    // A new sample is only produced while no point is being taken.
    `CRPI_ASSERT_SAME(a_out_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready), "sample appeared without work")

    // The rate register reads back what was written.
    `CRPI_ASSERT_NEXT(a_rate_rb, psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_STEP_RATE), (paddr[APB_ADDR_W-1:2] != REG_STEP_RATE) || (prdata == APB_DATA_W'($past(pwdata[RATE_W-1:0]))), "rate readback mismatch")

endmodule

bind catmull_rom_path_interpolator_unit crpi_checker u_crpi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

FILE: tb/tb_catmull_rom_path_interpolator_unit.sv
// Self-checking testbench for catmull_rom_path_interpolator_unit.
// Depends on crpi_pkg and the design sources; predicts every sample with its own
// fixed-point spline model and checks the output stream transfer by transfer.
`timescale 1ns / 1ps

module tb_catmull_rom_path_interpolator_unit;
    import crpi_pkg::*;

    // Phase arithmetic: one whole segment is 2^16 phase units.
    localparam int     PHASE_W   = 16;
    localparam longint PHASE_ONE = 65536;

    // Output saturation bounds of a 16-bit coordinate.
    localparam longint COORD_MAX = 32767;
    localparam longint COORD_MIN = -32768;

    // Legal range of the step_rate register for normal use.
    localparam logic [RATE_W-1:0] RATE_LOW  = 17'd1041;
    localparam logic [RATE_W-1:0] RATE_HIGH = 17'd65536;

    // The rate register is register 0, selected by paddr[2].
    localparam logic [APB_ADDR_W-1:0] STEP_RATE_ADDR = {REG_STEP_RATE, 2'b00};

    // Cycles allowed after the last sample for a point that makes no sample
    // or for the endpoint hand-off to finish.
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_POINTS = 420;

    // One output sample as it leaves the block.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               end_of_path;
    } sample_t;

    // One row of the directed table. A row may first change the rate; a row
    // marked typed carries its single expected endpoint sample explicitly.
    typedef struct packed {
        logic               set_rate;
        logic [RATE_W-1:0]  rate;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last_point;
        logic               typed;
        logic signed [15:0] want_x;
        logic signed [15:0] want_y;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;    // point_x, point_y
    logic                  s_axis_tlast  = 1'b0;  // last_point
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;          // out_x, out_y
    logic                  m_axis_tlast;          // end_of_path
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Spline model state: the four-point window (oldest first), the fill
    // count, the phase of the next sample and the shadow of step_rate.
    longint            window_x [4];
    longint            window_y [4];
    int                held_points;
    longint            pending_phase;
    logic [RATE_W-1:0] rate_reg;

    // Samples predicted for the point being sent, and all samples still owed
    // by the block in output order.
    sample_t point_samples [$];
    sample_t expected_samples [$];

    int fail_count     = 0;
    int src_idle_pct   = 36;
    int sink_stall_pct = 78;

    // Directed table: short paths, every rate extreme, saturation from
    // alternating full-scale points, the sample cap, a rate change while
    // points are held, and a path of exactly four points.
    plan_row_t directed_plan [0:25] = '{
        // Single point marked last: echoed back as the endpoint at once.
        '{1'b0, 17'd0, 16'sd32767, 16'sh8000, 1'b1, 1'b1, 16'sd32767, 16'sh8000},
        // Three-point path: nothing is interpolated, only the last point returns.
        '{1'b0, 17'd0, 16'sh8000, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd1, -16'sd1, 1'b1, 1'b1, 16'sd1, -16'sd1},
        // Lowest legal rate with full-scale zigzag: overshoot saturates and
        // the second segment runs into the per-segment sample cap.
        '{1'b1, 17'd1041, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd32767, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sh8000, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd32767, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sh8000, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        // Rate raised to one segment while points are held: the phase keeps
        // its value and only later additions use the new rate.
        '{1'b1, 17'd65536, 16'sd100, -16'sd100, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, -16'sd5, 16'sd7, 1'b1, 1'b0, 16'sd0, 16'sd0},
        // Register all ones acts as one segment; the first full window then
        // starts at phase one and makes no sample at all.
        '{1'b1, 17'h1ffff, 16'sd1000, 16'sd2000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, -16'sd3000, 16'sd4000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd5000, -16'sd6000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, -16'sd7000, 16'sd8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd9000, -16'sd10000, 1'b1, 1'b0, 16'sd0, 16'sd0},
        // Rate too small to reach one within the cap: the phase is forced to zero.
        '{1'b1, 17'd1000, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd12345, -16'sd12345, 1'b1, 1'b0, 16'sd0, 16'sd0},
        // Back to the reset rate; a lone origin point ends a path at once.
        '{1'b1, 17'd4096, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd0},
        // Path of exactly four points, the fourth one marked last.
        '{1'b0, 17'd0, 16'sd7, -16'sd7, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, -16'sd300, 16'sd300, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, 16'sd20000, -16'sd20000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 17'd0, -16'sd1, 16'sd1, 1'b1, 1'b0, 16'sd0, 16'sd0}
    };

    catmull_rom_path_interpolator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Rates above one segment behave as exactly one segment.
    function automatic longint capped_rate();
        return (rate_reg > PHASE_ONE) ? PHASE_ONE : longint'(rate_reg);
    endfunction

    function automatic void clear_path();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            window_x[i] = 0;
            window_y[i] = 0;
        end
        held_points   = 0;
        pending_phase = capped_rate();
    endfunction

    // Appends one sample at the tail of a sample queue.
    function automatic void append_sample(ref sample_t q [$], input sample_t s);
        q.insert(q.size(), s);
    endfunction

    // One coordinate of a Catmull-Rom sample at phase t. The weights are
    // doubled, so the sum is divided by two segments; adding one segment
    // first turns the floor into round-half-up.
    function automatic logic signed [15:0] blend_coord(input longint p0, input longint p1,
                                                       input longint p2, input longint p3,
                                                       input longint t);
        longint t2, t3, w0, w1, w2, w3, acc;
        t2  = (t * t) >>> PHASE_W;
        t3  = (t2 * t) >>> PHASE_W;
        w0  = -t3 + 2 * t2 - t;
        w1  = 3 * t3 - 5 * t2 + 2 * PHASE_ONE;
        w2  = -3 * t3 + 4 * t2 + t;
        w3  = t3 - t2;
        acc = p0 * w0 + p1 * w1 + p2 * w2 + p3 * w3 + PHASE_ONE;
        acc = acc >>> (PHASE_W + 1);
        if (acc > COORD_MAX)
            return 16'sh7fff;
        if (acc < COORD_MIN)
            return 16'sh8000;
        return acc[15:0];
    endfunction

    // Advances the spline model by one control point and leaves the samples
    // that point causes in point_samples.
    function automatic void predict_point(input logic signed [15:0] px,
                                          input logic signed [15:0] py,
                                          input logic last_point);
        int count;
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            window_x[i] = window_x[i + 1];
            window_y[i] = window_y[i + 1];
        end
        window_x[WIN_DEPTH - 1] = px;
        window_y[WIN_DEPTH - 1] = py;
        if (held_points < WIN_DEPTH)
            held_points++;

        if (held_points == WIN_DEPTH)
        begin
            // Sample the middle segment until the phase reaches one, but keep
            // one slot of the result budget for the endpoint.
            count = 0;
            while (pending_phase < PHASE_ONE && count < MAX_RESULTS - 1)
            begin
                append_sample(point_samples, sample_t'{
                    blend_coord(window_x[0], window_x[1], window_x[2], window_x[3],
                                pending_phase),
                    blend_coord(window_y[0], window_y[1], window_y[2], window_y[3],
                                pending_phase),
                    1'b0});
                count++;
                pending_phase += capped_rate();
            end
            if (pending_phase >= PHASE_ONE)
                pending_phase -= PHASE_ONE;
            else
                pending_phase = 0;
            if (last_point)
            begin
                append_sample(point_samples,
                              sample_t'{16'(window_x[2]), 16'(window_y[2]), 1'b1});
                clear_path();
            end
        end
        else if (last_point)
        begin
            // A path too short to interpolate just returns its final point.
            append_sample(point_samples, sample_t'{px, py, 1'b1});
            clear_path();
        end
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom);
            default: return 16'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(4))
            0:       return RATE_LOW;
            1:       return RATE_HIGH;
            2:       return 17'($urandom_range(65536, 1041));
            default: return 17'($urandom_range(16384, 2048));
        endcase
    endfunction

    // Offers one point on the input stream and records what it should produce.
    // The prediction is queued before the transfer completes; the point's own
    // samples cannot leave the block before it has been taken.
    task automatic feed_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic last_point, input logic typed,
                              input sample_t typed_sample);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tlast  <= last_point;
        point_samples.delete();
        predict_point(px, py, last_point);
        if (typed)
            append_sample(expected_samples, typed_sample);
        else
            foreach (point_samples[i])
                append_sample(expected_samples, point_samples[i]);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops sending, waits for every owed sample, then gives a point that
    // makes no sample time to retire inside the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_rate_reg(input logic [RATE_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= STEP_RATE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== APB_DATA_W'(want))
        begin
            $error("step_rate readback mismatch: expected %0d, got %0d", want, got);
            fail_count++;
        end
    endtask

    // Writes step_rate once the block is idle. With an empty window the write
    // also reloads the phase; with points held only later additions see it.
    task automatic rate_write(input logic [RATE_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STEP_RATE_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        rate_reg = value;
        if (held_points == 0)
            pending_phase = capped_rate();
        check_rate_reg(value);
    endtask

    // The sink accepts at random; sink_stall_pct sets how often it holds off.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Every output transfer is matched against the oldest owed sample.
    always @(posedge clk)
    begin : sample_check
        sample_t            want;
        logic signed [15:0] got_x;
        logic signed [15:0] got_y;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_x = m_axis_tdata[15:0];
            got_y = m_axis_tdata[31:16];
            if (expected_samples.size() == 0)
            begin
                $error("sample with no prediction: out_x %0d, out_y %0d, end_of_path %0b",
                       got_x, got_y, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got_x !== want.x)
                begin
                    $error("out_x mismatch: expected %0d, got %0d", want.x, got_x);
                    fail_count++;
                end
                if (got_y !== want.y)
                begin
                    $error("out_y mismatch: expected %0d, got %0d", want.y, got_y);
                    fail_count++;
                end
                if (m_axis_tlast !== want.end_of_path)
                begin
                    $error("end_of_path mismatch: expected %0b, got %0b",
                           want.end_of_path, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int                 points_sent;
        int                 path_len;
        int                 roll;
        logic signed [15:0] px;
        logic signed [15:0] py;

        rate_reg = RATE_W'(RATE_RESET);
        clear_path();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register must come out of reset at its documented value.
        check_rate_reg(RATE_W'(RATE_RESET));

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].set_rate)
                rate_write(directed_plan[i].rate);
            feed_point(directed_plan[i].x, directed_plan[i].y, directed_plan[i].last_point,
                       directed_plan[i].typed,
                       sample_t'{directed_plan[i].want_x, directed_plan[i].want_y, 1'b1});
        end

        // Random paths: mostly well-formed paths of four to ten points, with a
        // few short paths and a few long ones. Rates change at path starts and,
        // now and then, in the middle of a path while points are held.
        points_sent = 0;
        while (points_sent < RANDOM_POINTS)
        begin
            if ($urandom_range(4) == 0)
                rate_write(pick_rate());
            roll = $urandom_range(15);
            if (roll == 0)
                path_len = $urandom_range(3, 1);
            else if (roll == 1)
                path_len = $urandom_range(40, 20);
            else
                path_len = $urandom_range(10, 4);

            for (int k = 0; k < path_len; k++)
            begin
                // Swap the idling of the two sides after a third of the
                // points, and run with no idling for the last third.
                if (points_sent == RANDOM_POINTS / 3)
                begin
                    src_idle_pct   = 78;
                    sink_stall_pct = 36;
                end
                else if (points_sent == 2 * RANDOM_POINTS / 3)
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end

                roll = $urandom_range(99);
                if (roll < 2)
                    settle();
                else if (roll < 4)
                    rate_write(pick_rate());

                px = rand_coord();
                py = rand_coord();
                feed_point(px, py, k == path_len - 1, 1'b0, '0);
                points_sent++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
